/* rtl/mms_pkg.sv */
package mms_pkg;

    localparam int NUM_REGS    = 16;
    localparam int NUM_SLOTS   = 16;
    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = STK_AW + 1;

    typedef struct packed {
        logic [7:0]        code;
        logic [3:0]        dst;
        logic [3:0]        src;
        logic [3:0]        aux;
        logic              imm_sel;
        logic              jnz;
        logic [DATA_W-1:0] imm;
    } t_uop;

    localparam int UOP_W = $bits(t_uop);

    typedef logic [3:0] t_op;

    localparam t_op OP_MOV   = 4'd0;
    localparam t_op OP_XOR   = 4'd1;
    localparam t_op OP_OR    = 4'd2;
    localparam t_op OP_AND   = 4'd3;
    localparam t_op OP_ADD   = 4'd4;
    localparam t_op OP_ROTR  = 4'd5;
    localparam t_op OP_SHR   = 4'd6;
    localparam t_op OP_PATCH = 4'd7;
    localparam t_op OP_PULL  = 4'd8;
    localparam t_op OP_CH    = 4'd9;
    localparam t_op OP_MAJ   = 4'd10;
    localparam t_op OP_BSIG0 = 4'd11;
    localparam t_op OP_BSIG1 = 4'd12;
    localparam t_op OP_PUSH  = 4'd13;
    localparam t_op OP_JUMP  = 4'd14;
    localparam t_op OP_NONE  = 4'd15;

    localparam logic [4:0] BSIG0_R0 = 5'd2;
    localparam logic [4:0] BSIG0_R1 = 5'd13;
    localparam logic [4:0] BSIG0_R2 = 5'd22;
    localparam logic [4:0] BSIG1_R0 = 5'd6;
    localparam logic [4:0] BSIG1_R1 = 5'd11;
    localparam logic [4:0] BSIG1_R2 = 5'd25;

    function automatic logic [DATA_W-1:0] rotr(input logic [DATA_W-1:0] x,
                                               input logic [4:0] n);
        logic [2*DATA_W-1:0] w;
        w = {x, x} >> n;
        return w[DATA_W-1:0];
    endfunction

endpackage

/* rtl/mms_in_if.sv */
interface mms_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot_index;
    logic [7:0]  uop_code;
    logic [3:0]  dst_reg;
    logic [3:0]  src_reg;
    logic [3:0]  aux_reg;
    logic        use_imm;
    logic        jump_if_nonzero;
    logic [31:0] immediate;
    logic [15:0] slot_enables;
    logic        start_run;

    modport source (
        output valid, slot_index, uop_code, dst_reg, src_reg, aux_reg, use_imm,
               jump_if_nonzero, immediate, slot_enables, start_run,
        input  ready
    );

    modport sink (
        input  valid, slot_index, uop_code, dst_reg, src_reg, aux_reg, use_imm,
               jump_if_nonzero, immediate, slot_enables, start_run,
        output ready
    );
endinterface

/* rtl/mms_out_if.sv */
interface mms_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] ran_slots;
    logic [15:0] reg_changes;
    logic [15:0] stack_changes;
    logic [4:0]  jumps_taken;
    logic [15:0] fault_bits;

    modport source (
        output valid, ran_slots, reg_changes, stack_changes, jumps_taken,
               fault_bits,
        input  ready
    );

    modport sink (
        input  valid, ran_slots, reg_changes, stack_changes, jumps_taken,
               fault_bits,
        output ready
    );
endinterface

/* rtl/mms_ram.sv */
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mms_alu.sv */
module mms_alu (
    input  mms_pkg::t_op                i_op,
    input  logic [mms_pkg::DATA_W-1:0]  i_d,
    input  logic [mms_pkg::DATA_W-1:0]  i_s,
    input  logic [mms_pkg::DATA_W-1:0]  i_a,
    input  logic [mms_pkg::DATA_W-1:0]  i_imm,
    output logic [mms_pkg::DATA_W-1:0]  o_r
);

    always_comb begin
        case (i_op)
            mms_pkg::OP_MOV:   o_r = i_s;
            mms_pkg::OP_XOR:   o_r = i_d ^ i_s;
            mms_pkg::OP_OR:    o_r = i_d | i_s;
            mms_pkg::OP_AND:   o_r = i_d & i_s;
            mms_pkg::OP_ADD:   o_r = i_d + i_s;
            mms_pkg::OP_ROTR:  o_r = mms_pkg::rotr(i_d, i_s[4:0]);
            mms_pkg::OP_SHR:   o_r = i_d >> i_s[4:0];
            mms_pkg::OP_PATCH: o_r = i_d ^ ((i_d ^ i_s) & i_imm);
            mms_pkg::OP_CH:    o_r = (i_d & i_s) ^ (~i_d & i_a);
            mms_pkg::OP_MAJ:   o_r = (i_d & i_s) ^ (i_d & i_a) ^ (i_s & i_a);
            mms_pkg::OP_BSIG0: o_r = mms_pkg::rotr(i_s, mms_pkg::BSIG0_R0)
                                   ^ mms_pkg::rotr(i_s, mms_pkg::BSIG0_R1)
                                   ^ mms_pkg::rotr(i_s, mms_pkg::BSIG0_R2);
            mms_pkg::OP_BSIG1: o_r = mms_pkg::rotr(i_s, mms_pkg::BSIG1_R0)
                                   ^ mms_pkg::rotr(i_s, mms_pkg::BSIG1_R1)
                                   ^ mms_pkg::rotr(i_s, mms_pkg::BSIG1_R2);
            default:           o_r = i_d;
        endcase
    end

endmodule

/* rtl/masked_microop_sequencer.sv */
// A start word launches a run of 16 steps; no new word is taken until the run ends.
// A disabled step or one with an illegal code passes through FETCH and DEC; an executed
// step also passes RD_S, RD_A and EXEC, set by the single read port of the register file RAM.
// The result word is registered once the run ends and any earlier result has been taken.
// Synchronous active-low reset clears registers and stack through valid bits, and clears
// pointers and faults; program slots are undefined until loaded.
module masked_microop_sequencer #(
    parameter int NUM_REGS  = mms_pkg::NUM_REGS,
    parameter int NUM_SLOTS = mms_pkg::NUM_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mms_in_if.sink    i_in,
    mms_out_if.source o_res
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int REG_W  = $clog2(NUM_REGS);
    localparam int DW     = mms_pkg::DATA_W;
    localparam int SAW    = mms_pkg::STK_AW;
    localparam int SPW    = mms_pkg::SP_W;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_RD_S  = 3'd3;
    localparam logic [2:0] S_RD_A  = 3'd4;
    localparam logic [2:0] S_EXEC  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SPW-1:0]    SP_FULL   = SPW'(mms_pkg::STACK_DEPTH);

    logic [2:0]                r_state, n_state;
    logic [SLOT_W-1:0]         r_pc, n_pc;
    logic [SLOT_W-1:0]         r_step, n_step;
    logic [SPW-1:0]            r_sp, n_sp;
    logic [NUM_SLOTS-1:0]      r_faults, n_faults;
    logic [NUM_SLOTS-1:0]      r_mask, n_mask;
    logic [NUM_SLOTS-1:0]      r_exec, n_exec;
    logic [NUM_REGS-1:0]       r_chg_r, n_chg_r;
    logic [mms_pkg::STACK_DEPTH-1:0] r_chg_s, n_chg_s;
    logic [4:0]                r_jumps, n_jumps;
    logic [NUM_REGS-1:0]       r_rf_vld, n_rf_vld;
    logic [mms_pkg::STACK_DEPTH-1:0] r_stk_vld, n_stk_vld;
    logic                      r_rf_rv, n_rf_rv;
    logic                      r_stk_rv, n_stk_rv;
    logic                      r_out_vld, n_out_vld;
    logic [DW-1:0]             r_d, n_d;
    logic [DW-1:0]             r_s, n_s;
    logic [15:0]               r_out_exec, r_out_chg_r, r_out_chg_s, r_out_faults;
    logic [4:0]                r_out_jumps;

    logic                      w_accept;
    logic                      w_out_load;
    logic                      w_adv;
    logic [SLOT_W-1:0]         w_npc;
    logic                      w_pg_re;
    logic [mms_pkg::UOP_W-1:0] w_pg_wdata;
    logic [mms_pkg::UOP_W-1:0] w_pg_rdata;
    mms_pkg::t_uop             w_uop;
    mms_pkg::t_op              w_op;
    logic                      w_legal;
    logic                      w_rf_re;
    logic [REG_W-1:0]          w_rf_raddr;
    logic                      w_rf_we;
    logic [DW-1:0]             w_rf_wdata;
    logic [DW-1:0]             w_rf_rdata;
    logic [DW-1:0]             w_rf_q;
    logic                      w_stk_re;
    logic [SAW-1:0]            w_stk_raddr;
    logic                      w_stk_we;
    logic [SAW-1:0]            w_stk_waddr;
    logic [DW-1:0]             w_stk_wdata;
    logic [DW-1:0]             w_stk_rdata;
    logic [DW-1:0]             w_stk_q;
    logic [SAW-1:0]            w_sp_lo;
    logic [DW-1:0]             w_alu;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_LOAD);

    assign w_pg_wdata = {i_in.uop_code, i_in.dst_reg, i_in.src_reg, i_in.aux_reg,
                         i_in.use_imm, i_in.jump_if_nonzero, i_in.immediate};
    assign w_uop      = mms_pkg::t_uop'(w_pg_rdata);
    assign w_op       = w_uop.code[3:0];
    assign w_legal    = (w_uop.code[7:4] == 4'd0);
    assign w_rf_q     = r_rf_rv ? w_rf_rdata : '0;
    assign w_stk_q    = r_stk_rv ? w_stk_rdata : '0;
    assign w_sp_lo    = r_sp[SAW-1:0];

    mms_ram #(.WIDTH(mms_pkg::UOP_W), .DEPTH(NUM_SLOTS)) u_prog (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (i_in.slot_index),
        .i_wdata (w_pg_wdata),
        .i_re    (w_pg_re),
        .i_raddr (r_pc),
        .o_rdata (w_pg_rdata)
    );

    mms_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_rf_we),
        .i_waddr (w_uop.dst),
        .i_wdata (w_rf_wdata),
        .i_re    (w_rf_re),
        .i_raddr (w_rf_raddr),
        .o_rdata (w_rf_rdata)
    );

    mms_ram #(.WIDTH(DW), .DEPTH(mms_pkg::STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    mms_alu u_alu (
        .i_op  (w_op),
        .i_d   (r_d),
        .i_s   (r_s),
        .i_a   (w_rf_q),
        .i_imm (w_uop.imm),
        .o_r   (w_alu)
    );

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_step      = r_step;
        n_sp        = r_sp;
        n_faults    = r_faults;
        n_mask      = r_mask;
        n_exec      = r_exec;
        n_chg_r     = r_chg_r;
        n_chg_s     = r_chg_s;
        n_jumps     = r_jumps;
        n_rf_vld    = r_rf_vld;
        n_stk_vld   = r_stk_vld;
        n_rf_rv     = r_rf_rv;
        n_stk_rv    = r_stk_rv;
        n_d         = r_d;
        n_s         = r_s;
        w_out_load  = 1'b0;
        w_adv       = 1'b0;
        w_npc       = r_pc + 1'b1;
        w_pg_re     = 1'b0;
        w_rf_re     = 1'b0;
        w_rf_raddr  = w_uop.dst;
        w_rf_we     = 1'b0;
        w_rf_wdata  = w_alu;
        w_stk_re    = 1'b0;
        w_stk_raddr = w_sp_lo;
        w_stk_we    = 1'b0;
        w_stk_waddr = w_sp_lo;
        w_stk_wdata = r_s;

        case (r_state)
            S_LOAD: begin
                if (w_accept && i_in.start_run) begin
                    n_mask  = i_in.slot_enables;
                    n_exec  = '0;
                    n_chg_r = '0;
                    n_chg_s = '0;
                    n_jumps = '0;
                    n_step  = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                w_pg_re = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (!r_mask[r_pc]) begin
                    w_adv = 1'b1;
                end else if (!w_legal) begin
                    n_faults[r_pc] = 1'b1;
                    w_adv          = 1'b1;
                end else begin
                    n_exec[r_pc] = 1'b1;
                    w_rf_re      = 1'b1;
                    w_rf_raddr   = w_uop.dst;
                    n_state      = S_RD_S;
                end
            end
            S_RD_S: begin
                n_d        = w_rf_q;
                w_rf_re    = 1'b1;
                w_rf_raddr = w_uop.src;
                n_state    = S_RD_A;
            end
            S_RD_A: begin
                n_s         = w_uop.imm_sel ? w_uop.imm : w_rf_q;
                w_rf_re     = 1'b1;
                w_rf_raddr  = w_uop.aux;
                w_stk_re    = 1'b1;
                w_stk_raddr = (w_op == mms_pkg::OP_PULL) ? w_sp_lo - 1'b1 : w_sp_lo;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                w_adv = 1'b1;
                case (w_op)
                    mms_pkg::OP_PULL: begin
                        if (r_sp == '0) begin
                            n_faults[r_pc] = 1'b1;
                        end else begin
                            w_rf_we     = 1'b1;
                            w_rf_wdata  = w_stk_q;
                            w_stk_we    = 1'b1;
                            w_stk_waddr = w_sp_lo - 1'b1;
                            w_stk_wdata = '0;
                            n_sp        = r_sp - 1'b1;
                            if (w_stk_q != r_d) begin
                                n_chg_r[w_uop.dst] = 1'b1;
                            end
                            if (w_stk_q != '0) begin
                                n_chg_s[w_stk_waddr] = 1'b1;
                            end
                        end
                    end
                    mms_pkg::OP_PUSH: begin
                        if (r_sp == SP_FULL) begin
                            n_faults[r_pc] = 1'b1;
                        end else begin
                            w_stk_we = 1'b1;
                            n_sp     = r_sp + 1'b1;
                            if (w_stk_q != r_s) begin
                                n_chg_s[w_sp_lo] = 1'b1;
                            end
                        end
                    end
                    mms_pkg::OP_JUMP: begin
                        if (!w_uop.jnz || (r_s != '0)) begin
                            w_npc   = w_uop.imm[SLOT_W-1:0];
                            n_jumps = r_jumps + 5'd1;
                        end
                    end
                    mms_pkg::OP_NONE: begin
                    end
                    default: begin
                        w_rf_we = 1'b1;
                        if (w_alu != r_d) begin
                            n_chg_r[w_uop.dst] = 1'b1;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_vld) begin
                    w_out_load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (w_adv) begin
            n_pc    = w_npc;
            n_step  = r_step + 1'b1;
            n_state = (r_step == LAST_STEP) ? S_DONE : S_FETCH;
        end

        if (w_rf_re) begin
            n_rf_rv = r_rf_vld[w_rf_raddr];
        end
        if (w_stk_re) begin
            n_stk_rv = r_stk_vld[w_stk_raddr];
        end
        if (w_rf_we) begin
            n_rf_vld[w_uop.dst] = 1'b1;
        end
        if (w_stk_we) begin
            n_stk_vld[w_stk_waddr] = 1'b1;
        end

        if (w_out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_pc      <= '0;
            r_step    <= '0;
            r_sp      <= '0;
            r_faults  <= '0;
            r_mask    <= '0;
            r_exec    <= '0;
            r_chg_r   <= '0;
            r_chg_s   <= '0;
            r_jumps   <= '0;
            r_rf_vld  <= '0;
            r_stk_vld <= '0;
            r_rf_rv   <= 1'b0;
            r_stk_rv  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_step    <= n_step;
            r_sp      <= n_sp;
            r_faults  <= n_faults;
            r_mask    <= n_mask;
            r_exec    <= n_exec;
            r_chg_r   <= n_chg_r;
            r_chg_s   <= n_chg_s;
            r_jumps   <= n_jumps;
            r_rf_vld  <= n_rf_vld;
            r_stk_vld <= n_stk_vld;
            r_rf_rv   <= n_rf_rv;
            r_stk_rv  <= n_stk_rv;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        r_s <= n_s;
        if (w_out_load) begin
            r_out_exec   <= r_exec;
            r_out_chg_r  <= r_chg_r;
            r_out_chg_s  <= r_chg_s;
            r_out_jumps  <= r_jumps;
            r_out_faults <= r_faults;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.ran_slots     = r_out_exec;
    assign o_res.reg_changes   = r_out_chg_r;
    assign o_res.stack_changes = r_out_chg_s;
    assign o_res.jumps_taken   = r_out_jumps;
    assign o_res.fault_bits    = r_out_faults;

endmodule

/* rtl/mms_chk.sv */
module mms_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_start,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_exec,
    input logic [15:0] i_out_chg_r,
    input logic [15:0] i_out_chg_s,
    input logic [4:0]  i_out_jumps,
    input logic [15:0] i_out_faults
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result word dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_out_exec, i_out_chg_r, i_out_chg_s,
                                                 i_out_jumps, i_out_faults}))
        else $error("Stalled result word changed.");

    a_jump_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_jumps <= 5'd16))
        else $error("Jump count exceeds the run length.");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_start |=> !i_in_ready)
        else $error("Input taken while a run is in progress.");

    a_result_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("Result word appeared without a finished run.");

endmodule

bind masked_microop_sequencer mms_chk u_mms_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_start   (i_in.start_run),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_exec   (o_res.ran_slots),
    .i_out_chg_r  (o_res.reg_changes),
    .i_out_chg_s  (o_res.stack_changes),
    .i_out_jumps  (o_res.jumps_taken),
    .i_out_faults (o_res.fault_bits)
);
